// File: sv/smb_pkg.sv
`default_nettype none

package smb_pkg;

    localparam int WINDOW_BITS_DEF = 16;
    localparam int HALF_W          = 16;
    localparam int ABS_W           = 17;
    localparam int SUM_W           = 32;
    localparam int MEAN_W          = 32;
    localparam int GAIN_W          = 32;
    localparam int FRAC_BITS       = 16;
    localparam int RATIO_NUM_W     = MEAN_W + FRAC_BITS;
    localparam int CFG_WIN_W       = 16;
    localparam int CFG_THR_W       = 16;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 4;

    localparam logic [GAIN_W-1:0]    Q16_ONE      = 32'h0001_0000;
    localparam logic [GAIN_W-1:0]    GAIN_SAT     = 32'hFFFF_FFFF;
    localparam logic [CFG_WIN_W-1:0] WINDOW_RESET = 16'd1024;
    localparam logic                 SWAP_RESET   = 1'b0;
    localparam logic                 REF_RESET    = 1'b1;
    localparam logic [CFG_THR_W-1:0] THR_RESET    = 16'd0;

    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_SWAP_CHANNELS = 2'd1,
        REG_REFERENCE     = 2'd2,
        REG_THRESHOLD     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MEAN  = 2'd1,
        ST_RATIO = 2'd2,
        ST_OUT   = 2'd3
    } merge_state_t;

    typedef struct packed {
        logic add;
        logic last;
    } lane_ctrl_t;

    // Magnitude of a two's-complement half word; the most negative value gives 32768.
    function automatic logic [ABS_W-1:0] abs_half(input logic [HALF_W-1:0] half);
        logic [ABS_W-1:0] ext;
        ext = {1'b0, half};
        if (half[HALF_W-1])
        begin
            return (ABS_W'(1) << HALF_W) - ext;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

// File: sv/smb_div.sv
`default_nettype none

module smb_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Restoring division: one quotient bit per cycle, quotient shifts in as the
    // dividend shifts out of the same register.
    always_comb
    begin
        shifted = {rem_reg, work_reg[NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = work_reg;

endmodule

`default_nettype wire

// File: sv/smb_lane.sv
`default_nettype none

module smb_lane #(
    parameter int WINDOW_BITS = smb_pkg::WINDOW_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smb_pkg::lane_ctrl_t           ctrl,
    input  wire logic [smb_pkg::HALF_W-1:0]    sample,
    input  wire logic [WINDOW_BITS-1:0]        window,
    output logic                               mean_done,
    output logic [smb_pkg::MEAN_W-1:0]         mean
);

    import smb_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    assign sum_next = sum_reg + SUM_W'(abs_half(sample));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.add)
        begin
            sum_reg <= ctrl.last ? '0 : sum_next;
        end
    end

    smb_div #(
        .NUM_W (SUM_W),
        .DEN_W (WINDOW_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.add && ctrl.last),
        .num   (sum_next),
        .den   (window),
        .done  (mean_done),
        .quo   (mean)
    );

endmodule

`default_nettype wire

// File: sv/smb_merge.sv
`default_nettype none

module smb_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          mean_done,
    input  wire logic [smb_pkg::MEAN_W-1:0]    lmean,
    input  wire logic [smb_pkg::MEAN_W-1:0]    rmean,
    input  wire logic                          ref_right,
    input  wire logic [smb_pkg::CFG_THR_W-1:0] threshold,
    output logic                               busy,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        left_mean,
    output logic [15:0]                        right_mean,
    output logic [smb_pkg::GAIN_W-1:0]         left_gain,
    output logic [smb_pkg::GAIN_W-1:0]         right_gain,
    output logic                               gains_updated
);

    import smb_pkg::*;

    merge_state_t state_reg;
    merge_state_t state_next;

    logic [MEAN_W-1:0]      lm_reg;
    logic [MEAN_W-1:0]      rm_reg;
    logic                   upd_reg;
    logic [GAIN_W-1:0]      lgain_reg;
    logic [GAIN_W-1:0]      rgain_reg;
    logic                   out_valid_reg;
    logic [15:0]            out_lm_reg;
    logic [15:0]            out_rm_reg;
    logic [GAIN_W-1:0]      out_lgain_reg;
    logic [GAIN_W-1:0]      out_rgain_reg;
    logic                   out_upd_reg;

    logic [MEAN_W-1:0]      diff;
    logic                   upd;
    logic                   ratio_start;
    logic [MEAN_W-1:0]      ratio_num;
    logic [MEAN_W-1:0]      ratio_den;
    logic                   ratio_done;
    logic [RATIO_NUM_W-1:0] ratio_quo;
    logic [GAIN_W-1:0]      ratio_gain;
    logic                   den_zero_reg;
    logic                   load_out;

    always_comb
    begin
        diff        = (lmean >= rmean) ? (lmean - rmean) : (rmean - lmean);
        upd         = diff >= MEAN_W'(threshold);
        ratio_num   = ref_right ? rmean : lmean;
        ratio_den   = ref_right ? lmean : rmean;
        ratio_start = 1'b0;
        load_out    = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (mean_done)
                begin
                    ratio_start = upd;
                    state_next  = upd ? ST_RATIO : ST_OUT;
                end
            end
            ST_RATIO:
            begin
                if (ratio_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    smb_div #(
        .NUM_W (RATIO_NUM_W),
        .DEN_W (MEAN_W)
    ) u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ratio_start),
        .num   ({ratio_num, FRAC_BITS'(0)}),
        .den   (ratio_den),
        .done  (ratio_done),
        .quo   (ratio_quo)
    );

    // A zero divisor saturates the gain, which also covers two silent channels.
    assign ratio_gain = den_zero_reg ? GAIN_SAT : ratio_quo[GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lgain_reg     <= Q16_ONE;
            rgain_reg     <= Q16_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RATIO && ratio_done)
            begin
                if (ref_right)
                begin
                    lgain_reg <= ratio_gain;
                    rgain_reg <= Q16_ONE;
                end
                else
                begin
                    lgain_reg <= Q16_ONE;
                    rgain_reg <= ratio_gain;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEAN && mean_done)
        begin
            lm_reg       <= lmean;
            rm_reg       <= rmean;
            upd_reg      <= upd;
            den_zero_reg <= ratio_den == '0;
        end
        if (load_out)
        begin
            out_lm_reg    <= lm_reg[15:0];
            out_rm_reg    <= rm_reg[15:0];
            out_lgain_reg <= lgain_reg;
            out_rgain_reg <= rgain_reg;
            out_upd_reg   <= upd_reg;
        end
    end

    assign busy          = state_reg != ST_IDLE;
    assign out_valid     = out_valid_reg;
    assign left_mean     = out_lm_reg;
    assign right_mean    = out_rm_reg;
    assign left_gain     = out_lgain_reg;
    assign right_gain    = out_rgain_reg;
    assign gains_updated = out_upd_reg;

endmodule

`default_nettype wire

// File: sv/stereo_mic_balance_calibrator_top.sv
`default_nettype none

// Stereo microphone balance calibrator. Each transaction on the input brings one packed
// stereo word; a left and a right lane add the magnitudes of their halves, and after the
// last word of a window both lanes divide their sums by the window length in parallel,
// one quotient bit per cycle. When the means differ by at least the threshold, a
// 48-step shared divider forms the Q16.16 gain of the non-reference channel. A word
// that does not close a window causes no stall. After the word that closes a window
// the input stays stalled while the lanes divide and, when the gains are recomputed,
// while the shared divider runs, and then until the previous result has left the
// output register. Exactly one result transaction leaves per window.
module stereo_mic_balance_calibrator_top #(
    parameter int WINDOW_BITS = smb_pkg::WINDOW_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [smb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [smb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [smb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    stereo_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [15:0]                         left_mean,
    output logic [15:0]                         right_mean,
    output logic [smb_pkg::GAIN_W-1:0]          left_gain,
    output logic [smb_pkg::GAIN_W-1:0]          right_gain,
    output logic                                gains_updated
);

    import smb_pkg::*;

    localparam int EXT_W = (WINDOW_BITS > CFG_WIN_W) ? WINDOW_BITS : CFG_WIN_W;
    localparam logic [EXT_W-1:0] MAX_WIN = EXT_W'((64'd1 << WINDOW_BITS) - 64'd1);

    logic [CFG_WIN_W-1:0]   window_reg;
    logic                   swap_reg;
    logic                   ref_reg;
    logic [CFG_THR_W-1:0]   thr_reg;
    logic [WINDOW_BITS-1:0] cnt_reg;

    cfg_reg_t               cfg_sel;
    logic                   cfg_write;
    logic [EXT_W-1:0]       win_ext;
    logic [WINDOW_BITS-1:0] win_eff;
    logic [WINDOW_BITS-1:0] cnt_inc;
    logic                   window_end;
    logic                   accept;
    logic                   merge_busy;
    lane_ctrl_t             lane_ctrl;
    logic [HALF_W-1:0]      left_half;
    logic [HALF_W-1:0]      right_half;
    logic                   lmean_done;
    logic                   rmean_done;
    logic [MEAN_W-1:0]      lmean;
    logic [MEAN_W-1:0]      rmean;

    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_sel)
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(window_reg);
            REG_SWAP_CHANNELS: prdata = APB_DATA_W'(swap_reg);
            REG_REFERENCE:     prdata = APB_DATA_W'(ref_reg);
            REG_THRESHOLD:     prdata = APB_DATA_W'(thr_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            swap_reg   <= SWAP_RESET;
            ref_reg    <= REF_RESET;
            thr_reg    <= THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_WINDOW_LENGTH: window_reg <= pwdata[CFG_WIN_W-1:0];
                REG_SWAP_CHANNELS: swap_reg   <= pwdata[0];
                REG_REFERENCE:     ref_reg    <= pwdata[0];
                REG_THRESHOLD:     thr_reg    <= pwdata[CFG_THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // A zero length counts as one sample; lengths beyond the counter are clamped.
    always_comb
    begin
        win_ext = EXT_W'(window_reg);
        if (window_reg == '0)
        begin
            win_eff = WINDOW_BITS'(1);
        end
        else if (win_ext > MAX_WIN)
        begin
            win_eff = MAX_WIN[WINDOW_BITS-1:0];
        end
        else
        begin
            win_eff = win_ext[WINDOW_BITS-1:0];
        end
    end

    assign in_ready   = !merge_busy;
    assign accept     = in_valid && in_ready;
    assign cnt_inc    = cnt_reg + WINDOW_BITS'(1);
    // A window shortened mid-way also ends here once the count reaches or passes it.
    assign window_end = (cnt_inc == '0) || (cnt_inc >= win_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= window_end ? '0 : cnt_inc;
        end
    end

    assign lane_ctrl.add  = accept;
    assign lane_ctrl.last = window_end;
    assign left_half      = swap_reg ? stereo_word[31:16] : stereo_word[15:0];
    assign right_half     = swap_reg ? stereo_word[15:0] : stereo_word[31:16];

    smb_lane #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .sample    (left_half),
        .window    (win_eff),
        .mean_done (lmean_done),
        .mean      (lmean)
    );

    smb_lane #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .sample    (right_half),
        .window    (win_eff),
        .mean_done (rmean_done),
        .mean      (rmean)
    );

    smb_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept && window_end),
        .mean_done     (lmean_done),
        .lmean         (lmean),
        .rmean         (rmean),
        .ref_right     (ref_reg),
        .threshold     (thr_reg),
        .busy          (merge_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_mean     (left_mean),
        .right_mean    (right_mean),
        .left_gain     (left_gain),
        .right_gain    (right_gain),
        .gains_updated (gains_updated)
    );

`ifndef NO_ASSERTIONS
    a_stall_after_window: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && window_end) |=> !in_ready)
        else $error("input not stalled after the last word of a window");

    a_count_clear_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (cnt_reg == '0))
        else $error("sample count not cleared while a window result is computed");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lmean_done == rmean_done)
        else $error("left and right lanes finished on different cycles");

    a_updated_has_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gains_updated) |-> (left_gain == Q16_ONE || right_gain == Q16_ONE))
        else $error("updated gains carry no unity reference gain");
`endif

endmodule

`default_nettype wire

// File: test/stereo_mic_balance_calibrator_top_tb.sv
`timescale 1ns / 100ps

module stereo_mic_balance_calibrator_top_tb;

    import smb_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 550;

    typedef struct {
        logic [15:0] lmean;
        logic [15:0] rmean;
        logic [31:0] lgain;
        logic [31:0] rgain;
        logic        upd;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] stereo_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] left_mean;
    logic [15:0] right_mean;
    logic [31:0] left_gain;
    logic [31:0] right_gain;
    logic        gains_updated;

    // Calibration state as the block should hold it.
    logic [15:0] cfg_window = WINDOW_RESET;
    logic        cfg_swap = SWAP_RESET;
    logic        cfg_ref_right = REF_RESET;
    logic [15:0] cfg_threshold = THR_RESET;
    logic [15:0] window_count = '0;
    logic [31:0] left_sum = '0;
    logic [31:0] right_sum = '0;
    logic [31:0] left_gain_now = Q16_ONE;
    logic [31:0] right_gain_now = Q16_ONE;

    window_result_t expected_windows[$];
    window_result_t oldest;
    logic [31:0]    word_queue[$];

    int queued_words = 0;
    int accepted_words = 0;
    int windows_seen = 0;
    int gain_updates = 0;
    int reg_writes = 0;
    int errors = 0;
    int stall_cycles = 0;

    logic in_fire = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_cycles = 0;
    logic steady_sender = 1'b0;
    logic steady_receiver = 1'b0;
    logic pressure_armed = 1'b0;
    logic pressure_done = 1'b0;

    stereo_mic_balance_calibrator_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stereo_word(stereo_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_mean(left_mean),
        .right_mean(right_mean),
        .left_gain(left_gain),
        .right_gain(right_gain),
        .gains_updated(gains_updated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] magnitude(input logic [15:0] half);
        if (half[15])
        begin
            return 32'h0001_0000 - {16'h0, half};
        end
        return {16'h0, half};
    endfunction

    function automatic logic [31:0] q16_gain(input logic [31:0] num, input logic [31:0] den);
        logic [63:0] quotient;
        if (den == 32'd0)
        begin
            return GAIN_SAT;
        end
        quotient = {16'h0, num, 16'h0} / {32'h0, den};
        return quotient[31:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [15:0] pick_half();
        logic [15:0] mag;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'h7FFF;
                    3: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
            1:
            begin
                mag = 16'($urandom_range(0, 300));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        logic [15:0] half;
        half = pick_half();
        case ($urandom_range(0, 5))
            0: return {half, half};
            1: return {half, -half};
            2: return {16'h0000, half};
            3: return {half, 16'h0000};
            default: return {pick_half(), half};
        endcase
    endfunction

    // Adds one stereo word to the running sums and queues the window result when it closes.
    task automatic accumulate_word(input logic [31:0] word);
        logic [31:0]    upper;
        logic [31:0]    lower;
        logic [31:0]    span;
        logic [31:0]    lm;
        logic [31:0]    rm;
        logic [31:0]    diff;
        window_result_t res;
        upper = magnitude(word[31:16]);
        lower = magnitude(word[15:0]);
        span = (cfg_window == 16'd0) ? 32'd1 : {16'h0, cfg_window};
        if (cfg_swap)
        begin
            left_sum = left_sum + upper;
            right_sum = right_sum + lower;
        end
        else
        begin
            left_sum = left_sum + lower;
            right_sum = right_sum + upper;
        end
        window_count = window_count + 16'd1;
        if (window_count != 16'd0 && {16'h0, window_count} < span)
        begin
            return;
        end
        lm = left_sum / span;
        rm = right_sum / span;
        diff = (lm >= rm) ? lm - rm : rm - lm;
        res.upd = 1'b0;
        if (diff >= {16'h0, cfg_threshold})
        begin
            res.upd = 1'b1;
            if (cfg_ref_right)
            begin
                left_gain_now = q16_gain(rm, lm);
                right_gain_now = Q16_ONE;
            end
            else
            begin
                right_gain_now = q16_gain(lm, rm);
                left_gain_now = Q16_ONE;
            end
        end
        res.lmean = lm[15:0];
        res.rmean = rm[15:0];
        res.lgain = left_gain_now;
        res.rgain = right_gain_now;
        expected_windows.push_back(res);
        window_count = '0;
        left_sum = '0;
        right_sum = '0;
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: window %0d %s expected %h, got %h", $realtime, windows_seen,
                     label, want, got);
        end
    endtask

    // Sampling side: prediction on every accepted word, checking on every accepted result.
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            accumulate_word(stereo_word);
            accepted_words++;
        end
        if (out_valid && out_ready)
        begin
            if (expected_windows.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with no window pending, got means %h/%h",
                         $realtime, left_mean, right_mean);
            end
            else
            begin
                oldest = expected_windows.pop_front();
                compare_field("left_mean", {16'h0, oldest.lmean}, {16'h0, left_mean});
                compare_field("right_mean", {16'h0, oldest.rmean}, {16'h0, right_mean});
                compare_field("left_gain", oldest.lgain, left_gain);
                compare_field("right_gain", oldest.rgain, right_gain);
                compare_field("gains_updated", {31'h0, oldest.upd}, {31'h0, gains_updated});
                if (oldest.upd)
                begin
                    gain_updates++;
                end
            end
            windows_seen++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("stereo_mic_balance_calibrator_top: mismatch");
                $finish;
            end
        end
    end

    // Input driver.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (word_queue.size() > 0 && send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (word_queue.size() > 0)
            begin
                stereo_word <= word_queue.pop_front();
                in_valid <= 1'b1;
                send_gap <= steady_sender ? 0 : pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver; one long hold-off lets the block fill up and stall its input.
    always @(negedge clk)
    begin
        if (pressure_armed && !pressure_done && out_valid)
        begin
            hold_cycles <= HOLD_CYCLES;
            pressure_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap <= steady_receiver ? 0 : pick_gap();
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW_LENGTH: cfg_window = value[15:0];
            REG_SWAP_CHANNELS: cfg_swap = value[0];
            REG_REFERENCE:     cfg_ref_right = value[0];
            REG_THRESHOLD:     cfg_threshold = value[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Bits above each register's width carry noise; the block must ignore them.
    task automatic configure(input logic [15:0] win, input logic swap_sel,
                             input logic ref_right, input logic [15:0] thr);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(REG_WINDOW_LENGTH, {noise[31:16], win});
        write_reg(REG_SWAP_CHANNELS, {noise[30:0], swap_sel});
        write_reg(REG_REFERENCE, {noise[31:1], ref_right});
        write_reg(REG_THRESHOLD, {noise[15:0], thr});
    endtask

    task automatic push_word(input logic [31:0] word);
        word_queue.push_back(word);
        queued_words++;
    endtask

    // Waits until every word is in and every window result is out, then lets the
    // block finish any computation still in flight.
    task automatic settle();
        while (accepted_words != queued_words || expected_windows.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int          random_words;
        int          count;
        int          r;
        logic [15:0] win;
        logic [15:0] thr;

        random_words = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One-sample windows: silent input saturates the gain, full-scale halves.
        configure(16'd1, 1'b0, 1'b1, 16'd0);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(32'h8000_0001);
        push_word(32'h7FFF_8000);
        push_word(32'h0001_0000);
        settle();

        // A zero window acts as one sample; swapped halves, left reference, top threshold.
        configure(16'd0, 1'b1, 1'b0, 16'd32768);
        push_word(32'h8000_0000);
        push_word(32'h0000_8000);
        push_word(32'h1234_5678);
        settle();

        // Shortening the window mid-way closes it on the next word without clearing sums.
        configure(16'd4, 1'b0, 1'b1, 16'd100);
        push_word(32'h0100_7FFF);
        push_word(32'hFF00_8001);
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd2);
        push_word(32'h0010_0020);
        settle();

        // Longest window, cut short so the left mean overflows its 16-bit output.
        configure(16'hFFFF, 1'b1, 1'b0, 16'd0);
        repeat (8) push_word(32'h8000_0001);
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd3);
        push_word(32'h8000_0001);
        settle();

        // Back-to-back windows while the receiver holds off.
        configure(16'd1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'd0);
        steady_sender = 1'b1;
        pressure_armed = 1'b1;
        repeat (60) push_word(pick_word());
        random_words += 60;
        settle();
        steady_sender = 1'b0;
        pressure_armed = 1'b0;

        while (random_words < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                win = 16'd0;
            end
            else if (r < 20)
            begin
                win = 16'd1;
            end
            else if (r < 75)
            begin
                win = 16'($urandom_range(2, 8));
            end
            else if (r < 95)
            begin
                win = 16'($urandom_range(9, 40));
            end
            else
            begin
                win = 16'($urandom_range(41, 150));
            end
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                thr = 16'd0;
            end
            else if (r < 30)
            begin
                thr = 16'd32768;
            end
            else if (r < 70)
            begin
                thr = 16'($urandom_range(0, 200));
            end
            else
            begin
                thr = 16'($urandom_range(0, 32768));
            end
            configure(win, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), thr);
            steady_sender = ($urandom_range(0, 3) == 0);
            steady_receiver = ($urandom_range(0, 3) == 0);
            count = $urandom_range(10, 60);
            repeat (count) push_word(pick_word());
            random_words += count;
            settle();
        end

        if (expected_windows.size() != 0)
        begin
            errors++;
            $display("%0t: %0d window results never arrived", $realtime,
                     expected_windows.size());
        end
        $display("Run covered %0d stereo words and %0d closed windows, %0d of them with new gains.",
                 accepted_words, windows_seen, gain_updates);
        $display("Window lengths ran from 0 to 65535 over %0d register writes, both channel orders.",
                 reg_writes);
        if (errors == 0)
        begin
            $display("stereo_mic_balance_calibrator_top: match");
        end
        else
        begin
            $display("stereo_mic_balance_calibrator_top: mismatch");
        end
        $finish;
    end

endmodule

// File: stereo_mic_balance_calibrator_top.f
sv/smb_pkg.sv
sv/smb_div.sv
sv/smb_lane.sv
sv/smb_merge.sv
sv/stereo_mic_balance_calibrator_top.sv
test/stereo_mic_balance_calibrator_top_tb.sv
